[rtl/core/rcbr_pkg.sv]
// ----------------------------------------------------------------------------
// rcbr_pkg
// Shared types, constants and table functions for the biphase bit recovery
// block: register map, configuration record and the quarter-wave sine model.
// ----------------------------------------------------------------------------
package rcbr_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned SINE_DEPTH_DEF   = 256;
  localparam int unsigned SLIP_LIMIT_DEF   = 16;

  // Fixed field and state widths.
  localparam int unsigned IN_W       = 16;
  localparam int unsigned TRIG_W     = 16;
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned CLK_W      = 16;
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned BETA_W     = 16;
  localparam int unsigned PERIOD_W   = 14;
  localparam int unsigned THRESH_W   = 15;

  // Shared multiplier and datapath widths.
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned ROT_W      = 33;
  localparam int unsigned EG_W       = 31;
  localparam int unsigned INC_W      = 26;

  // Loop and symbol clock constants.
  localparam int unsigned INV_TWO_PI_Q16 = 10430;
  localparam int unsigned ROT_SHIFT      = 15;
  localparam int unsigned GAIN_SHIFT     = 23;
  localparam int unsigned PHASE_FRAC     = 8;
  localparam int unsigned PHASE_ROUND    = 128;
  localparam int unsigned CLOCK_STEP     = 256;
  localparam int unsigned CLOCK_NUDGE    = 26;
  localparam int unsigned QUARTER_TURN   = 16384;

  // Configuration port.
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd2048;
  localparam logic [BETA_W-1:0]   BETA_RST   = 16'd64;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 14'd1294;
  localparam logic [THRESH_W-1:0] THRESH_RST = 15'd3277;

  typedef enum logic [1:0] {
    REG_ALPHA  = 2'd0,
    REG_BETA   = 2'd1,
    REG_PERIOD = 2'd2,
    REG_THRESH = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ALPHA_W-1:0]  alpha;
    logic [BETA_W-1:0]   beta;
    logic [PERIOD_W-1:0] period;
    logic [THRESH_W-1:0] thresh;
  } cfg_t;

  // Odd polynomial over one quadrant; the argument is a Q0.14 position.
  function automatic longint quarter_sine(input longint x14);
    longint x;
    longint x2;
    longint inner;
    longint mid;
    longint y;
    x     = x14 * 2;
    x2    = (x * x) >>> 15;
    inner = 21167 - ((2611 * x2) >>> 15);
    mid   = 51472 - ((inner * x2) >>> 15);
    y     = (x * mid) >>> 15;
    return (y > 32767) ? 32767 : y;
  endfunction

  // Sine of a Q0.16 fraction of a turn, mirrored into all four quadrants.
  function automatic logic signed [TRIG_W-1:0] sine_of_turn(input logic [PHASE_W-1:0] t);
    longint r;
    longint v;
    r = longint'(t[13:0]);
    v = t[14] ? quarter_sine(longint'(QUARTER_TURN) - r) : quarter_sine(r);
    if (t[15]) begin
      v = -v;
    end
    return TRIG_W'(v);
  endfunction

endpackage

[rtl/core/rcbr_apb_regs.sv]
// ----------------------------------------------------------------------------
// rcbr_apb_regs
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module rcbr_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcbr_pkg::APB_AW-1:0]  paddr,
  input  logic [rcbr_pkg::APB_DW-1:0]  pwdata,
  output logic [rcbr_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output rcbr_pkg::cfg_t               cfg_o
);
  import rcbr_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha  <= ALPHA_RST;
      cfg_q.beta   <= BETA_RST;
      cfg_q.period <= PERIOD_RST;
      cfg_q.thresh <= THRESH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ALPHA:  cfg_q.alpha  <= pwdata[ALPHA_W-1:0];
        REG_BETA:   cfg_q.beta   <= pwdata[BETA_W-1:0];
        REG_PERIOD: cfg_q.period <= pwdata[PERIOD_W-1:0];
        REG_THRESH: cfg_q.thresh <= pwdata[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ALPHA:  prdata = APB_DW'(cfg_q.alpha);
      REG_BETA:   prdata = APB_DW'(cfg_q.beta);
      REG_PERIOD: prdata = APB_DW'(cfg_q.period);
      REG_THRESH: prdata = APB_DW'(cfg_q.thresh);
      default:    prdata = '0;
    endcase
  end

endmodule

[rtl/core/rcbr_sincos_rom.sv]
// ----------------------------------------------------------------------------
// rcbr_sincos_rom
// Sine and cosine table of the loop phase, quantised to the table depth,
// with registered read data.
// ----------------------------------------------------------------------------
module rcbr_sincos_rom #(
  parameter int unsigned DEPTH = rcbr_pkg::SINE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [rcbr_pkg::PHASE_W-1:0]        phase_i,
  output logic signed [rcbr_pkg::TRIG_W-1:0]  sin_o,
  output logic signed [rcbr_pkg::TRIG_W-1:0]  cos_o
);
  import rcbr_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic signed [TRIG_W-1:0]       sin_tab [DEPTH];
  logic signed [TRIG_W-1:0]       cos_tab [DEPTH];
  logic [PHASE_W+IDX_W-1:0]       scaled;
  logic [IDX_W-1:0]               idx;

  // Each entry holds the value at the start of its bin; the cosine is the
  // same curve a quarter turn further on.
  for (genvar k = 0; k < DEPTH; k++) begin : g_tab
    localparam logic [PHASE_W-1:0] T = PHASE_W'((k << PHASE_W) / DEPTH);
    assign sin_tab[k] = sine_of_turn(T);
    assign cos_tab[k] = sine_of_turn(PHASE_W'(T + PHASE_W'(QUARTER_TURN)));
  end

  assign scaled = (PHASE_W+IDX_W)'(phase_i) * (PHASE_W+IDX_W)'(DEPTH);
  assign idx    = scaled[PHASE_W +: IDX_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= sin_tab[idx];
      cos_o <= cos_tab[idx];
    end
  end

endmodule

[rtl/core/rcbr_mul.sv]
// ----------------------------------------------------------------------------
// rcbr_mul
// Shared signed multiplier with a registered product, used for the rotation,
// the error and both loop gains in turn.
// ----------------------------------------------------------------------------
module rcbr_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [rcbr_pkg::MUL_W-1:0]   a_i,
  input  logic signed [rcbr_pkg::MUL_W-1:0]   b_i,
  output logic signed [rcbr_pkg::PROD_W-1:0]  prod_o
);
  import rcbr_pkg::*;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

endmodule

[rtl/core/rds_costas_biphase_bit_recovery.sv]
// A new sample is not accepted until the last one has been through every step,
// since the eight products of each sample go in turn through the single
// shared multiplier.
// A waiting result does not stop the next sample; only a second result held
// up behind it stalls the sequencer in its last step.
// Reset clears all loop, clock and pairing state; registers take their defaults.
// ----------------------------------------------------------------------------
// rds_costas_biphase_bit_recovery
// BPSK Costas loop with symbol clock recovery, biphase half-symbol pairing,
// slip voting and differential decoding, sequenced around one multiplier.
// ----------------------------------------------------------------------------
module rds_costas_biphase_bit_recovery #(
  parameter int unsigned SAMPLE_WIDTH     = rcbr_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = rcbr_pkg::SINE_DEPTH_DEF,
  parameter int unsigned SLIP_VOTE_LIMIT  = rcbr_pkg::SLIP_LIMIT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [rcbr_pkg::IN_W-1:0]   bb_i_i,
  input  logic signed [rcbr_pkg::IN_W-1:0]   bb_q_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               data_bit_o,
  output logic                               locked_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rcbr_pkg::APB_AW-1:0]        paddr,
  input  logic [rcbr_pkg::APB_DW-1:0]        pwdata,
  output logic [rcbr_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import rcbr_pkg::*;

  localparam int unsigned VOTE_W = $clog2(SLIP_VOTE_LIMIT + 1);
  localparam int unsigned CLK1_W = CLK_W + 1;

  localparam logic signed [ROT_W-1:0] SMAX =
    ROT_W'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - longint'(1));
  localparam logic signed [ROT_W-1:0] SMIN =
    ROT_W'(-(longint'(1) <<< (SAMPLE_WIDTH - 1)));
  localparam logic signed [INC_W-1:0] FREQ_MAX =
    INC_W'((longint'(1) <<< (FREQ_W - 1)) - longint'(1));
  localparam logic signed [INC_W-1:0] FREQ_MIN =
    INC_W'(-(longint'(1) <<< (FREQ_W - 1)));
  localparam logic signed [PROD_W-1:0] ERR_MAX =
    PROD_W'((longint'(1) <<< (ERR_W - 1)) - longint'(1));
  localparam logic signed [PROD_W-1:0] ERR_MIN =
    PROD_W'(-(longint'(1) <<< (ERR_W - 1)));

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_IC,
    S_MUL_QS,
    S_MUL_QC,
    S_MUL_IS,
    S_ROT_Q,
    S_MUL_ERR,
    S_ERR,
    S_MUL_EG,
    S_MUL_BETA,
    S_MUL_ALPHA,
    S_UPD
  } state_e;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [ROT_W-1:0] x
  );
    logic signed [ROT_W-1:0] y;
    if (x > SMAX) begin
      y = SMAX;
    end else if (x < SMIN) begin
      y = SMIN;
    end else begin
      y = x;
    end
    return SAMPLE_WIDTH'(y);
  endfunction

  cfg_t cfg;

  state_e state_q;

  logic signed [IN_W-1:0]          si_q;
  logic signed [IN_W-1:0]          sq_q;
  logic signed [TRIG_W-1:0]        sin_val;
  logic signed [TRIG_W-1:0]        cos_val;
  logic signed [ROT_W-1:0]         acc_q;
  logic signed [SAMPLE_WIDTH-1:0]  ri_q;
  logic signed [SAMPLE_WIDTH-1:0]  rq_q;
  logic signed [ERR_W-1:0]         err_q;
  logic signed [EG_W-1:0]          eg_q;
  logic                            locked_q;
  logic [PHASE_W-1:0]              phase_q;
  logic signed [FREQ_W-1:0]        freq_q;
  logic [CLK_W-1:0]                sclk_q;
  logic [CLK1_W-1:0]               clk1_q;
  logic                            take_q;
  logic                            prevneg_q;
  logic signed [SAMPLE_WIDTH-1:0]  held_q;
  logic                            hv_q;
  logic [VOTE_W-1:0]               votes_q;
  logic                            prev_enc_q;
  logic                            out_valid_q;
  logic                            data_bit_q;
  logic                            locked_out_q;

  logic                            in_fire;
  logic                            mul_en;
  logic signed [MUL_W-1:0]         mul_a;
  logic signed [MUL_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]        prod;
  logic signed [ROT_W-1:0]         prod_rot;
  logic signed [ROT_W-1:0]         rot_i_sum;
  logic signed [ROT_W-1:0]         rot_q_sum;
  logic signed [PROD_W-1:0]        prod_sh15;
  logic signed [PROD_W-1:0]        prod_sh23;
  logic signed [INC_W-1:0]         gain_adj;
  logic signed [EG_W-1:0]          prod_eg;
  logic signed [ERR_W-1:0]         err_sat;
  logic [ERR_W:0]                  err_abs;
  logic signed [INC_W-1:0]         freq_sum;
  logic signed [INC_W-1:0]         freq_sat;
  logic signed [INC_W-1:0]         inc_rnd;
  logic                            neg;
  logic [CLK1_W-1:0]               clk_base;
  logic [CLK1_W-1:0]               clk_nudged;
  logic [CLK1_W-1:0]               period_ext;
  logic                            take;
  logic signed [SAMPLE_WIDTH:0]    pair_diff;
  logic                            enc;
  logic                            same_sign;
  logic                            vote_over;
  logic                            has_result;
  logic                            out_free;
  logic                            out_load;

  rcbr_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcbr_sincos_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (in_fire),
    .phase_i (phase_q),
    .sin_o   (sin_val),
    .cos_o   (cos_val)
  );

  rcbr_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign data_bit_o  = data_bit_q;
  assign locked_o    = locked_out_q;

  // Operand selection for the shared multiplier, at most one product per step.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_MUL_IC: begin
        mul_a = MUL_W'(si_q);
        mul_b = MUL_W'(cos_val);
      end
      S_MUL_QS: begin
        mul_a = MUL_W'(sq_q);
        mul_b = MUL_W'(sin_val);
      end
      S_MUL_QC: begin
        mul_a = MUL_W'(sq_q);
        mul_b = MUL_W'(cos_val);
      end
      S_MUL_IS: begin
        mul_a = MUL_W'(si_q);
        mul_b = MUL_W'(sin_val);
      end
      S_MUL_ERR: begin
        mul_a = MUL_W'(ri_q);
        mul_b = MUL_W'(rq_q);
      end
      S_MUL_EG: begin
        mul_a = MUL_W'(err_q);
        mul_b = MUL_W'(INV_TWO_PI_Q16);
      end
      S_MUL_BETA: begin
        mul_a = MUL_W'({1'b0, cfg.beta});
        mul_b = MUL_W'(prod_eg);
      end
      S_MUL_ALPHA: begin
        mul_a = MUL_W'({1'b0, cfg.alpha});
        mul_b = MUL_W'(eg_q);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Rotation, error and loop arithmetic on the registered product.
  assign prod_rot  = ROT_W'(prod);
  assign rot_i_sum = (acc_q + prod_rot) >>> ROT_SHIFT;
  assign rot_q_sum = (acc_q - prod_rot) >>> ROT_SHIFT;
  assign prod_sh15 = prod >>> ROT_SHIFT;
  assign prod_sh23 = prod >>> GAIN_SHIFT;
  assign gain_adj  = INC_W'(prod_sh23);
  assign prod_eg   = prod[EG_W-1:0];

  always_comb begin
    if (prod_sh15 > ERR_MAX) begin
      err_sat = ERR_W'(ERR_MAX);
    end else if (prod_sh15 < ERR_MIN) begin
      err_sat = ERR_W'(ERR_MIN);
    end else begin
      err_sat = ERR_W'(prod_sh15);
    end
  end

  assign err_abs = err_q[ERR_W-1] ? (ERR_W+1)'(-(ERR_W+1)'(err_q)) : (ERR_W+1)'(err_q);

  assign freq_sum = INC_W'(freq_q) + gain_adj;
  always_comb begin
    if (freq_sum > FREQ_MAX) begin
      freq_sat = FREQ_MAX;
    end else if (freq_sum < FREQ_MIN) begin
      freq_sat = FREQ_MIN;
    end else begin
      freq_sat = freq_sum;
    end
  end

  // The phase step is rounded to the nearest 2^-16 turn.
  assign inc_rnd = INC_W'(freq_q) + gain_adj + INC_W'(PHASE_ROUND);

  // Symbol clock: count a sample and nudge toward mid-period on a crossing.
  assign neg        = ri_q[SAMPLE_WIDTH-1];
  assign clk_base   = CLK1_W'(sclk_q) + CLK1_W'(CLOCK_STEP);
  assign period_ext = CLK1_W'(cfg.period);
  always_comb begin
    clk_nudged = clk_base;
    if (neg != prevneg_q) begin
      if (clk_base > CLK1_W'(cfg.period >> 1)) begin
        clk_nudged = clk_base - CLK1_W'(CLOCK_NUDGE);
      end else begin
        clk_nudged = clk_base + CLK1_W'(CLOCK_NUDGE);
      end
    end
  end
  assign take = (clk1_q >= period_ext);

  // Pairing of half-symbols.
  assign pair_diff  = (SAMPLE_WIDTH+1)'(held_q) - (SAMPLE_WIDTH+1)'(ri_q);
  assign enc        = !pair_diff[SAMPLE_WIDTH] && (pair_diff != '0);
  assign same_sign  = (held_q[SAMPLE_WIDTH-1] == ri_q[SAMPLE_WIDTH-1]);
  assign vote_over  = ((VOTE_W+1)'(votes_q) + (VOTE_W+1)'(1)) > (VOTE_W+1)'(SLIP_VOTE_LIMIT);
  assign has_result = take_q & hv_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == S_UPD) && has_result && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      si_q         <= '0;
      sq_q         <= '0;
      acc_q        <= '0;
      ri_q         <= '0;
      rq_q         <= '0;
      err_q        <= '0;
      eg_q         <= '0;
      locked_q     <= 1'b0;
      phase_q      <= '0;
      freq_q       <= '0;
      sclk_q       <= '0;
      clk1_q       <= '0;
      take_q       <= 1'b0;
      prevneg_q    <= 1'b0;
      held_q       <= '0;
      hv_q         <= 1'b0;
      votes_q      <= '0;
      prev_enc_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      data_bit_q   <= 1'b0;
      locked_out_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            si_q    <= bb_i_i;
            sq_q    <= bb_q_i;
            state_q <= S_MUL_IC;
          end
        end
        S_MUL_IC: begin
          state_q <= S_MUL_QS;
        end
        S_MUL_QS: begin
          acc_q   <= prod_rot;
          state_q <= S_MUL_QC;
        end
        S_MUL_QC: begin
          ri_q    <= sat_sample(rot_i_sum);
          state_q <= S_MUL_IS;
        end
        S_MUL_IS: begin
          acc_q   <= prod_rot;
          state_q <= S_ROT_Q;
        end
        S_ROT_Q: begin
          rq_q      <= sat_sample(rot_q_sum);
          clk1_q    <= clk_nudged;
          prevneg_q <= neg;
          state_q   <= S_MUL_ERR;
        end
        S_MUL_ERR: begin
          state_q <= S_ERR;
        end
        S_ERR: begin
          err_q   <= err_sat;
          take_q  <= take;
          sclk_q  <= take ? CLK_W'(clk1_q - period_ext) : clk1_q[CLK_W-1:0];
          state_q <= S_MUL_EG;
        end
        S_MUL_EG: begin
          locked_q <= (err_abs < (ERR_W+1)'(cfg.thresh));
          state_q  <= S_MUL_BETA;
        end
        S_MUL_BETA: begin
          eg_q    <= prod_eg;
          state_q <= S_MUL_ALPHA;
        end
        S_MUL_ALPHA: begin
          freq_q  <= FREQ_W'(freq_sat);
          state_q <= S_UPD;
        end
        S_UPD: begin
          // With a result due, nothing commits until the output register is free.
          if (!has_result || out_free) begin
            phase_q <= phase_q + inc_rnd[PHASE_FRAC +: PHASE_W];
            if (take_q) begin
              if (!hv_q) begin
                held_q <= ri_q;
                hv_q   <= 1'b1;
              end else begin
                hv_q <= 1'b0;
                if (same_sign) begin
                  if (vote_over) begin
                    votes_q <= '0;
                    held_q  <= ri_q;
                    hv_q    <= 1'b1;
                  end else begin
                    votes_q <= votes_q + VOTE_W'(1);
                  end
                end else if (votes_q != '0) begin
                  votes_q <= votes_q - VOTE_W'(1);
                end
                prev_enc_q   <= enc;
                data_bit_q   <= enc ^ prev_enc_q;
                locked_out_q <= locked_q;
                out_valid_q  <= 1'b1;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[verif/tb_rds_costas_biphase_bit_recovery.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rds_costas_biphase_bit_recovery
// Self-checking bench for the Costas biphase bit recovery block. A queue of
// baseband samples feeds a valid/ready driver, and a monitor predicts each
// decoded bit and lock flag in step with the accepted samples. It compares
// every result beat with the oldest prediction. Register settings change
// between phases over the APB port, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_rds_costas_biphase_bit_recovery;

  localparam int unsigned  CLK_PERIOD    = 8;
  localparam int unsigned  RESET_CYCLES  = 12;
  localparam int unsigned  SETTLE_CYCLES = 40;
  localparam longint       TIMEOUT_NS    = 64'd8_000_000;
  localparam int unsigned  PHASE_ITEMS   = 250;

  localparam int unsigned  TABLE_DEPTH   = 256;
  localparam int unsigned  SLIP_LIMIT    = 16;
  localparam longint       SMAX          = 32767;
  localparam longint       SMIN          = -32768;
  localparam longint       GAIN_SCALE    = 10430;
  localparam longint       CLOCK_ADVANCE = 256;
  localparam longint       NUDGE         = 26;

  typedef struct packed {
    logic signed [15:0] i;
    logic signed [15:0] q;
  } sample_t;

  typedef struct packed {
    logic data_bit;
    logic locked;
  } bit_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic signed [rcbr_pkg::IN_W-1:0]     bb_i = '0;
  logic signed [rcbr_pkg::IN_W-1:0]     bb_q = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic                                 data_bit;
  logic                                 locked;
  logic                                 psel = 1'b0;
  logic                                 penable = 1'b0;
  logic                                 pwrite = 1'b0;
  logic [rcbr_pkg::APB_AW-1:0]          paddr = '0;
  logic [rcbr_pkg::APB_DW-1:0]          pwdata = '0;
  logic [rcbr_pkg::APB_DW-1:0]          prdata;
  logic                                 pready;

  rds_costas_biphase_bit_recovery i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .bb_i_i      (bb_i),
    .bb_q_i      (bb_q),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .data_bit_o  (data_bit),
    .locked_o    (locked),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sample_t     pending_samples[$];
  bit_result_t predicted_bits[$];
  int unsigned error_count = 0;

  // Demodulator state as the block should hold it.
  rcbr_pkg::cfg_t     loop_cfg = '{alpha:  rcbr_pkg::ALPHA_RST,
                                   beta:   rcbr_pkg::BETA_RST,
                                   period: rcbr_pkg::PERIOD_RST,
                                   thresh: rcbr_pkg::THRESH_RST};
  logic [15:0]        phase_acc    = '0;
  logic signed [23:0] loop_freq    = '0;
  logic [15:0]        symbol_clock = '0;
  logic               was_negative = 1'b0;
  logic signed [15:0] held_half    = '0;
  logic               half_waiting = 1'b0;
  logic [4:0]         slip_count   = '0;
  logic               prev_enc     = 1'b0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Sine table entry for a Q0.16 angle: odd polynomial over one quadrant,
  // reflected for the second half of each half-turn and negated below zero.
  function automatic longint rom_sine(input logic [15:0] ang);
    longint x, xx, c1, c2, y;
    x  = ang[14] ? 2 * (16384 - longint'(ang[13:0])) : 2 * longint'(ang[13:0]);
    xx = (x * x) >>> 15;
    c1 = 21167 - ((2611 * xx) >>> 15);
    c2 = 51472 - ((c1 * xx) >>> 15);
    y  = (x * c2) >>> 15;
    if (y > 32767) begin
      y = 32767;
    end
    return ang[15] ? -y : y;
  endfunction

  // Advances the demodulator by one sample; returns 1 when a pair completes.
  function automatic bit demod_sample(input logic signed [15:0] in_i,
                                      input logic signed [15:0] in_q,
                                      output bit_result_t res);
    longint si, sq, idx, ang, sn, cs, ri, rq, err, nf, inc, clk;
    logic   enc;
    logic   neg;
    res = '0;
    si  = in_i;
    sq  = in_q;
    idx = (longint'(phase_acc) * TABLE_DEPTH) >>> 16;
    ang = ((idx << 16) / TABLE_DEPTH) & 64'hFFFF;
    sn  = rom_sine(ang[15:0]);
    cs  = rom_sine(ang[15:0] + 16'd16384);

    ri  = clamp((si * cs + sq * sn) >>> 15, SMIN, SMAX);
    rq  = clamp((sq * cs - si * sn) >>> 15, SMIN, SMAX);
    err = clamp((ri * rq) >>> 15, -32768, 32767);

    nf        = longint'(loop_freq) + ((longint'(loop_cfg.beta) * err * GAIN_SCALE) >>> 23);
    loop_freq = 24'(clamp(nf, -8388608, 8388607));
    inc       = longint'(loop_freq) + ((longint'(loop_cfg.alpha) * err * GAIN_SCALE) >>> 23);
    phase_acc = 16'(longint'(phase_acc) + ((inc + 128) >>> 8));
    res.locked = (((err < 0) ? -err : err) < longint'(loop_cfg.thresh));

    // Symbol clock: pull towards mid-period on each zero crossing.
    neg = (ri < 0);
    clk = longint'(symbol_clock) + CLOCK_ADVANCE;
    if (neg != was_negative) begin
      clk = (clk > (longint'(loop_cfg.period) >> 1)) ? clk - NUDGE : clk + NUDGE;
    end
    was_negative = neg;
    if (clk < longint'(loop_cfg.period)) begin
      symbol_clock = 16'(clk);
      return 1'b0;
    end
    symbol_clock = 16'(clk - longint'(loop_cfg.period));

    if (!half_waiting) begin
      held_half    = 16'(ri);
      half_waiting = 1'b1;
      return 1'b0;
    end

    enc          = ((longint'(held_half) - ri) > 0);
    half_waiting = 1'b0;
    if ((held_half < 0) == (ri < 0)) begin
      if (int'(slip_count) + 1 > int'(SLIP_LIMIT)) begin
        // Too many like-signed pairs: slide the pairing by one half.
        slip_count   = '0;
        held_half    = 16'(ri);
        half_waiting = 1'b1;
      end else begin
        slip_count = slip_count + 5'd1;
      end
    end else if (slip_count != 0) begin
      slip_count = slip_count - 5'd1;
    end

    res.data_bit = enc ^ prev_enc;
    prev_enc     = enc;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Per-beat wait, with occasional runs of beats that do not wait at all.
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(20, 60);
    end
    return $urandom_range(0, 14);
  endfunction

  // Sample driver.
  sample_t     next_smp;
  int unsigned send_wait = 0;
  int unsigned send_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        next_smp  = pending_samples.pop_front();
        bb_i     <= next_smp.i;
        bb_q     <= next_smp.q;
        in_valid <= 1'b1;
        send_wait = draw_wait(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver.
  int unsigned recv_wait = 0;
  int unsigned recv_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        recv_wait = draw_wait(recv_calm);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each accepted sample beat, check each result beat.
  bit_result_t predicted;
  bit_result_t oldest;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (predicted_bits.size() == 0) begin
          report_mismatch("result beat with no bit pending");
        end else begin
          oldest = predicted_bits.pop_front();
          if (data_bit !== oldest.data_bit) begin
            report_mismatch($sformatf("data_bit %b, predicted %b", data_bit, oldest.data_bit));
          end
          if (locked !== oldest.locked) begin
            report_mismatch($sformatf("locked %b, predicted %b", locked, oldest.locked));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (demod_sample(bb_i, bb_q, predicted)) begin
          predicted_bits.insert(predicted_bits.size(), predicted);
        end
      end
    end
  end

  function automatic logic signed [15:0] corner_value(input int unsigned k);
    case (k)
      0:       return 16'sh8000;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return 16'sh7FFF;
    endcase
  endfunction

  task automatic queue_sample(input logic signed [15:0] i_val, input logic signed [15:0] q_val);
    sample_t s;
    s.i = i_val;
    s.q = q_val;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  // Biphase stream at the configured half-symbol rate with a fixed tilt and
  // noise; an occasional bit has two like-signed halves. With steady set the
  // level never changes, which drives the slip voting to its limit.
  task automatic queue_biphase(input int unsigned len, input bit steady);
    int unsigned acc, n;
    int          amp, tilt, noise, a, b;
    bit          pos, second;
    amp    = $urandom_range(1000, 32767);
    tilt   = int'($urandom_range(0, 2 * amp)) - amp;
    noise  = $urandom_range(0, 4000);
    acc    = $urandom_range(0, loop_cfg.period);
    pos    = $urandom_range(0, 1);
    second = 1'b0;
    for (n = 0; n < len; n++) begin
      acc += 256;
      if (acc >= loop_cfg.period) begin
        acc -= loop_cfg.period;
        if (!steady) begin
          if (second) begin
            pos = ($urandom_range(0, 7) == 0) ? pos : !pos;
          end else begin
            pos = $urandom_range(0, 1);
          end
          second = !second;
        end
      end
      a = (pos ? amp : -amp) + int'($urandom_range(0, 2 * noise)) - noise;
      b = (pos ? tilt : -tilt) + int'($urandom_range(0, 2 * noise)) - noise;
      queue_sample(16'(clamp(a, SMIN, SMAX)), 16'(clamp(b, SMIN, SMAX)));
    end
  endtask

  // Waits until every sample has gone in and every bit has come out, then
  // lets the pipeline drain samples that produce no bit.
  task automatic settle();
    @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid || predicted_bits.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input rcbr_pkg::reg_idx_e idx, input int unsigned val);
    logic [31:0] word;
    word       = $urandom();
    word[15:0] = val[15:0];
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rcbr_pkg::REG_ALPHA:  loop_cfg.alpha  = word[15:0];
      rcbr_pkg::REG_BETA:   loop_cfg.beta   = word[15:0];
      rcbr_pkg::REG_PERIOD: loop_cfg.period = word[13:0];
      default:              loop_cfg.thresh = word[14:0];
    endcase
  endtask

  task automatic set_config(input int unsigned alpha, input int unsigned beta,
                            input int unsigned period, input int unsigned thresh);
    apb_write(rcbr_pkg::REG_ALPHA, alpha);
    apb_write(rcbr_pkg::REG_BETA, beta);
    apb_write(rcbr_pkg::REG_PERIOD, period);
    apb_write(rcbr_pkg::REG_THRESH, thresh);
  endtask

  task automatic run_random(input int unsigned items);
    int unsigned sent, len, pick, k;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        len = $urandom_range(20, 120);
        queue_biphase(len, 1'b0);
      end else if (pick < 14) begin
        len = $urandom_range(40, 200);
        queue_biphase(len, 1'b1);
      end else begin
        len = $urandom_range(1, 20);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(0, 2))
            0:       queue_sample(16'($urandom()), 16'($urandom()));
            1:       queue_sample(corner_value($urandom_range(0, 4)),
                                  corner_value($urandom_range(0, 4)));
            default: queue_sample(16'(int'($urandom_range(0, 1023)) - 512),
                                  16'(int'($urandom_range(0, 1023)) - 512));
          endcase
        end
      end
      sent += len;
    end
    settle();
  endtask

  initial begin
    int unsigned a, b;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every pairing of the corner values -32768, -1, 0, 1 and 32767, at the reset settings.
    for (a = 0; a < 5; a++) begin
      for (b = 0; b < 5; b++) begin
        queue_sample(corner_value(a), corner_value(b));
      end
    end
    settle();

    set_config(0, 0, 512, 0);
    run_random(PHASE_ITEMS);
    set_config(65535, 65535, 16383, 32767);
    run_random(PHASE_ITEMS);
    set_config(4096, 128, 1294, 3277);
    run_random(PHASE_ITEMS);
    // Period shorter than one sample: a half-symbol on every sample.
    set_config($urandom_range(0, 65535), $urandom_range(0, 4096), 200,
               $urandom_range(0, 32767));
    run_random(PHASE_ITEMS);
    repeat (4) begin
      set_config($urandom_range(0, 65535), $urandom_range(0, 8192),
                 $urandom_range(512, 3000), $urandom_range(0, 32767));
      run_random(PHASE_ITEMS);
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
